// ===== rtl/timestamped_pi_speed_loop_assert.svh =====
// assertion macros for the speed loop
// expects clk_i and rst_ni in the scope of each use
`ifndef TIMESTAMPED_PI_SPEED_LOOP_ASSERT_SVH
`define TIMESTAMPED_PI_SPEED_LOOP_ASSERT_SVH

// same-cycle implication
`define TSPL_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("speed loop check failed");

// next-cycle implication
`define TSPL_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("speed loop check failed");

`endif

// ===== rtl/tspl_pkg.sv =====
// shared types and constants for the timestamped speed pi loop
// no dependencies
package tspl_pkg;

  localparam int unsigned GAIN_W   = 24;
  localparam int unsigned LIMIT_W  = 17;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned SPEED_W  = 15;
  localparam int unsigned ERR_W    = 16;
  localparam int unsigned DT_W     = 8;
  localparam int unsigned TORQUE_W = 18;
  localparam int unsigned INC_W    = GAIN_W + DT_W + ERR_W;
  localparam int unsigned PROP_W   = GAIN_W + ERR_W;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TORQUE_LIMIT = 2'd2;

  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST    = 24'd2013266;
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST   = 24'd13422;
  localparam logic [LIMIT_W-1:0] TORQUE_LIMIT_RST = 17'd64000;

  localparam logic [DT_W-1:0] DT_BACKWARD_MS = 8'd10;
  localparam logic [DT_W-1:0] DT_MIN_MS      = 8'd1;
  localparam logic [DT_W-1:0] DT_MAX_MS      = 8'd200;

  typedef struct packed {
    logic start;
    logic clear;
  } tspl_post_ctl_t;

endpackage

// ===== rtl/tspl_ser_mul.sv =====
// bit-serial unsigned shift-add multiplier, one multiplier bit per cycle
// no package dependencies
module tspl_ser_mul #(
  parameter int unsigned AW = 24,
  parameter int unsigned BW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic             done_o,
  output logic [AW+BW-1:0] p_o
);

  localparam int unsigned CW = $clog2(BW + 1);

  logic [AW-1:0]    a_q;
  logic [AW+BW-1:0] acc_q, acc_d;
  logic [AW:0]      sum;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;

  always_comb begin
    sum   = {1'b0, acc_q[AW+BW-1:BW]} + (acc_q[0] ? {1'b0, a_q} : {(AW+1){1'b0}});
    acc_d = {sum, acc_q[BW-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(BW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      acc_q <= {{AW{1'b0}}, b_i};
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

// ===== rtl/tspl_post.sv =====
// integrator update with saturation, output sum, clamp and conversion that drops 16 fractional bits
// depends on tspl_pkg
module tspl_post #(
  parameter int unsigned INTEG_WIDTH = 48
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tspl_pkg::tspl_post_ctl_t        ctl_i,
  input  logic                            neg_i,
  input  logic [tspl_pkg::INC_W-1:0]      inc_mag_i,
  input  logic [tspl_pkg::PROP_W-1:0]     prop_mag_i,
  input  logic [tspl_pkg::LIMIT_W-1:0]    limit_i,
  output logic                            done_o,
  output logic signed [tspl_pkg::TORQUE_W-1:0] res_o
);
  import tspl_pkg::*;

  localparam int unsigned IW = INTEG_WIDTH;
  localparam int unsigned SW = ((IW > INC_W + 1) ? IW : INC_W + 1) + 1;
  localparam int unsigned EW = (IW > 44) ? IW : 44;
  localparam int unsigned PW = PROP_W + 1;
  localparam int unsigned TW = 45;

  localparam logic signed [SW-1:0] IMAX   = (SW'(1) << (IW - 1)) - SW'(1);
  localparam logic signed [SW-1:0] IMIN   = -IMAX - SW'(1);
  localparam logic signed [EW-1:0] IC_MAX = EW'(1) << 42;
  localparam logic signed [EW-1:0] IC_MIN = -IC_MAX;

  logic signed [IW-1:0] integ_q, integ_d;
  logic signed [SW-1:0] sum_q, sum_d, ie, bz;
  logic signed [PW-1:0] pc_q, pc_d;
  logic signed [EW-1:0] iext, icl;
  logic signed [43:0]   ic44;
  logic signed [TW-1:0] tot_q, tot_d, lim, tc;
  logic signed [TORQUE_W-1:0] res_q;
  logic [3:0]           v_q;

  always_comb begin
    ie    = SW'(integ_q);
    bz    = signed'({{(SW - INC_W){1'b0}}, inc_mag_i});
    sum_d = neg_i ? (ie - bz) : (ie + bz);
    pc_d  = neg_i ? -signed'({1'b0, prop_mag_i}) : signed'({1'b0, prop_mag_i});

    if (sum_q > IMAX) begin
      integ_d = IMAX[IW-1:0];
    end else if (sum_q < IMIN) begin
      integ_d = IMIN[IW-1:0];
    end else begin
      integ_d = sum_q[IW-1:0];
    end

    iext = EW'(integ_q);
    if (iext > IC_MAX) begin
      icl = IC_MAX;
    end else if (iext < IC_MIN) begin
      icl = IC_MIN;
    end else begin
      icl = iext;
    end
    ic44  = icl[43:0];
    tot_d = TW'(ic44) + TW'(pc_q);

    lim = signed'({12'b0, limit_i, 16'b0});
    if (tot_q > lim) begin
      tc = lim;
    end else if (tot_q < -lim) begin
      tc = -lim;
    end else begin
      tc = tot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      integ_q <= '0;
    end else begin
      v_q <= {v_q[2:0], ctl_i.start};
      if (ctl_i.clear) begin
        integ_q <= '0;
      end else if (v_q[0]) begin
        integ_q <= integ_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      sum_q <= sum_d;
      pc_q  <= pc_d;
    end
    if (v_q[1]) begin
      tot_q <= tot_d;
    end
    if (v_q[2]) begin
      res_q <= tc[33:16];
    end
  end

  assign done_o = v_q[3];
  assign res_o  = res_q;

endmodule

// ===== rtl/timestamped_pi_speed_loop.sv =====
// timestamped speed pi loop, top level: control sequencer, config and stream ports
// depends on tspl_pkg, tspl_ser_mul, tspl_post and the assertion macro header
//
// channel   | dir | handshake               | payload
// s_axis    | in  | s_axis_tvalid/tready    | tuser mode, tdata time/target/measured
// m_axis    | out | m_axis_tvalid/tready    | tdata torque_demand
// cfg       | in  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// an update transaction runs from accept to result as 8 serial steps for gain times step
// time, then 16 serial steps for the error products, then a four-stage integrator and
// clamp pipeline. a start transaction goes from accept straight to the output state.
// reset is asynchronous and active low and restores the register defaults.
// a finished result waits in the output register while the next input is taken.
`include "timestamped_pi_speed_loop_assert.svh"

module timestamped_pi_speed_loop #(
  parameter int unsigned INTEG_WIDTH = 48
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [31:0] time_ms, [46:32] speed_target, [61:47] speed_measured, [63:62] zero
  input  logic [63:0]                        s_axis_tdata,
  // [0] mode
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [17:0] torque_demand, [23:18] zero
  output logic [23:0]                        m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tspl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tspl_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import tspl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DT,
    S_MA,
    S_MB,
    S_POST,
    S_OUT
  } state_e;

  state_e state_q;

  logic [GAIN_W-1:0]   prop_q, igain_q;
  logic [LIMIT_W-1:0]  limit_q;

  logic [TIME_W-1:0]   time_q, last_q, diff;
  logic signed [ERR_W-1:0] err_q, err_d;
  logic [ERR_W-1:0]    err_mag;
  logic                start_q;
  logic [DT_W-1:0]     dt;
  logic signed [TORQUE_W-1:0] res_q, post_res;
  logic                out_valid_q;
  logic [TORQUE_W-1:0] out_data_q;

  logic                in_acc, out_load;
  logic                ma_start, mb_start;
  logic                ma_done, mb_done, mc_done;
  logic [GAIN_W+DT_W-1:0] prod_a;
  logic [INC_W-1:0]    prod_b;
  logic [PROP_W-1:0]   prod_c;
  tspl_post_ctl_t      post_ctl;
  logic                post_done;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);
  assign ma_start      = (state_q == S_DT);
  assign mb_start      = (state_q == S_MA) && ma_done;
  assign post_ctl.start = (state_q == S_MB) && mb_done;
  assign post_ctl.clear = in_acc && s_axis_tuser;

  assign err_d   = signed'({s_axis_tdata[46], s_axis_tdata[46:32]})
                 - signed'({s_axis_tdata[61], s_axis_tdata[61:47]});
  assign err_mag = err_q[ERR_W-1] ? ERR_W'(-err_q) : ERR_W'(err_q);

  always_comb begin
    diff = time_q - last_q;
    if (time_q < last_q) begin
      dt = DT_BACKWARD_MS;
    end else if (diff == '0) begin
      dt = DT_MIN_MS;
    end else if (diff > TIME_W'(DT_MAX_MS)) begin
      dt = DT_MAX_MS;
    end else begin
      dt = diff[DT_W-1:0];
    end
  end

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_q  <= PROP_GAIN_RST;
      igain_q <= INTEG_GAIN_RST;
      limit_q <= TORQUE_LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_PROP_GAIN:    prop_q  <= cfg_data_i[GAIN_W-1:0];
        REG_INTEG_GAIN:   igain_q <= cfg_data_i[GAIN_W-1:0];
        REG_TORQUE_LIMIT: limit_q <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      time_q      <= '0;
      last_q      <= '0;
      err_q       <= '0;
      start_q     <= 1'b0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_data_q  <= res_q;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            time_q  <= s_axis_tdata[TIME_W-1:0];
            err_q   <= err_d;
            start_q <= s_axis_tuser;
            if (s_axis_tuser) begin
              last_q  <= s_axis_tdata[TIME_W-1:0];
              res_q   <= '0;
              state_q <= S_OUT;
            end else begin
              state_q <= S_DT;
            end
          end
        end
        S_DT: begin
          last_q  <= time_q;
          state_q <= S_MA;
        end
        S_MA: begin
          if (ma_done) begin
            state_q <= S_MB;
          end
        end
        S_MB: begin
          if (mb_done) begin
            state_q <= S_POST;
          end
        end
        S_POST: begin
          if (post_done) begin
            res_q   <= post_res;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_data_q};

  // integ_gain * step time
  tspl_ser_mul #(.AW(GAIN_W), .BW(DT_W)) u_mul_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ma_start),
    .a_i     (igain_q),
    .b_i     (dt),
    .done_o  (ma_done),
    .p_o     (prod_a)
  );

  // |error| * integ_gain * step time
  tspl_ser_mul #(.AW(GAIN_W + DT_W), .BW(ERR_W)) u_mul_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mb_start),
    .a_i     (prod_a),
    .b_i     (err_mag),
    .done_o  (mb_done),
    .p_o     (prod_b)
  );

  // |error| * prop_gain
  tspl_ser_mul #(.AW(GAIN_W), .BW(ERR_W)) u_mul_c (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mb_start),
    .a_i     (prop_q),
    .b_i     (err_mag),
    .done_o  (mc_done),
    .p_o     (prod_c)
  );

  tspl_post #(.INTEG_WIDTH(INTEG_WIDTH)) u_post (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (post_ctl),
    .neg_i      (err_q[ERR_W-1]),
    .inc_mag_i  (prod_b),
    .prop_mag_i (prod_c),
    .limit_i    (limit_q),
    .done_o     (post_done),
    .res_o      (post_res)
  );

  `TSPL_ASSERT_NEXT(a_busy_after_accept, in_acc, !s_axis_tready)
  `TSPL_ASSERT_IMPL(a_mul_lockstep, mb_done, mc_done)
  `TSPL_ASSERT_IMPL(a_post_done_in_post, post_done, state_q == S_POST)
  `TSPL_ASSERT_NEXT(a_start_gives_zero, out_load && start_q, out_data_q == '0)

endmodule

// ===== tb/timestamped_pi_speed_loop_tb.sv =====
// testbench for the timestamped speed pi loop: directed and random stream traffic
// checked against a fixed-point predictor kept in the bench; depends on tspl_pkg and the rtl
module timestamped_pi_speed_loop_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tspl_pkg::*;

  localparam int unsigned INTEG_W = 48;
  localparam longint INTEG_MAX = (64'sd1 <<< (INTEG_W - 1)) - 1;
  localparam longint INTEG_CAP = 64'sd1 <<< 42;

  typedef struct packed {
    logic               start;
    logic [TIME_W-1:0]  time_ms;
    logic [SPEED_W-1:0] target;
    logic [SPEED_W-1:0] measured;
  } speed_sample_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [63:0]           s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [23:0]           m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // predictor state and register copies
  longint            gain_p = PROP_GAIN_RST;
  longint            gain_i = INTEG_GAIN_RST;
  longint            torque_lim = TORQUE_LIMIT_RST;
  longint            integ_acc = 0;
  logic [TIME_W-1:0] prev_time = '0;

  speed_sample_t       sample_fifo[$];
  logic [TORQUE_W-1:0] torque_q[$];
  speed_sample_t       on_bus;
  logic [TORQUE_W-1:0] torque_want;
  logic [TIME_W-1:0]   gen_time = '0;
  int                  src_gap = 0;
  int                  sink_hold = 0;
  bit                  idle_on = 1'b1;
  bit                  stall_req = 1'b0;
  int                  fail_count = 0;
  int                  n_updates = 0;
  int                  n_starts = 0;
  int                  n_cfg = 0;

  always #5 clk_i = ~clk_i;

  timestamped_pi_speed_loop #(
    .INTEG_WIDTH(INTEG_W)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  function automatic logic [TORQUE_W-1:0] predict_torque(input speed_sample_t s);
    longint err;
    longint inc;
    longint ic;
    longint sum;
    longint lim;
    longint step_ms;
    if (s.start) begin
      integ_acc = 0;
      prev_time = s.time_ms;
      n_starts++;
      return '0;
    end
    n_updates++;
    if (s.time_ms >= prev_time) step_ms = s.time_ms - prev_time;
    else step_ms = DT_BACKWARD_MS;
    if (step_ms < DT_MIN_MS) step_ms = DT_MIN_MS;
    else if (step_ms > DT_MAX_MS) step_ms = DT_MAX_MS;
    err = $signed(s.target);
    err = err - $signed(s.measured);
    inc = err * gain_i * step_ms;
    if (inc > 0 && integ_acc > INTEG_MAX - inc) integ_acc = INTEG_MAX;
    else if (inc < 0 && integ_acc < -INTEG_MAX - 1 - inc) integ_acc = -INTEG_MAX - 1;
    else integ_acc = integ_acc + inc;
    ic = integ_acc;
    if (ic > INTEG_CAP) ic = INTEG_CAP;
    else if (ic < -INTEG_CAP) ic = -INTEG_CAP;
    sum = err * gain_p + ic;
    lim = torque_lim <<< 16;
    if (sum > lim) sum = lim;
    else if (sum < -lim) sum = -lim;
    prev_time = s.time_ms;
    // arithmetic shift rounds toward minus infinity
    sum = sum >>> 16;
    return sum[TORQUE_W-1:0];
  endfunction

  // sender
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) torque_q.push_back(predict_torque(on_bus));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
          src_gap = $urandom_range(0, 16);
          s_axis_tvalid <= 1'b0;
        end else if (sample_fifo.size() != 0) begin
          on_bus = sample_fifo.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= on_bus.start;
          s_axis_tdata  <= {2'b00, on_bus.measured, on_bus.target, on_bus.time_ms};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and result check
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_hold = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (torque_q.size() == 0) begin
          $error("torque_demand: no transaction expected, actual %0d",
                 $signed(m_axis_tdata[TORQUE_W-1:0]));
          fail_count++;
        end else begin
          torque_want = torque_q.pop_front();
          if (m_axis_tdata[TORQUE_W-1:0] !== torque_want) begin
            $error("torque_demand mismatch: expected %0d actual %0d",
                   $signed(torque_want), $signed(m_axis_tdata[TORQUE_W-1:0]));
            fail_count++;
          end
        end
      end
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else if (stall_req) begin
        stall_req = 1'b0;
        sink_hold = 299;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        sink_hold = $urandom_range(0, 16);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // register copies follow each accepted write
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      n_cfg++;
      case (cfg_index_i)
        REG_PROP_GAIN:    gain_p = cfg_data_i;
        REG_INTEG_GAIN:   gain_i = cfg_data_i;
        REG_TORQUE_LIMIT: torque_lim = cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_sample(input logic start, input logic [TIME_W-1:0] t,
                             input logic [SPEED_W-1:0] tgt, input logic [SPEED_W-1:0] meas);
    speed_sample_t s;
    s.start    = start;
    s.time_ms  = t;
    s.target   = tgt;
    s.measured = meas;
    sample_fifo.push_back(s);
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (sample_fifo.size() != 0 || s_axis_tvalid || torque_q.size() != 0);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_value(input int unsigned w);
    case ($urandom_range(0, 3))
      0: return '0;
      1: return CFG_DATA_W'((32'd1 << w) - 1);
      default: return CFG_DATA_W'($urandom & ((32'd1 << $urandom_range(1, w)) - 1));
    endcase
  endfunction

  // mostly advancing timestamps with setpoints near the measured speed
  task automatic random_burst(input int n);
    int                 pick;
    logic [SPEED_W-1:0] tgt;
    logic [SPEED_W-1:0] meas;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) gen_time += $urandom_range(0, 30);
      else if (pick < 85) gen_time += $urandom_range(31, 400);
      else if (pick < 93) gen_time -= $urandom_range(1, 600);
      else gen_time = $urandom;
      tgt = SPEED_W'($urandom);
      if ($urandom_range(0, 2) != 0) meas = tgt - SPEED_W'($urandom_range(0, 64)) + 15'd32;
      else meas = SPEED_W'($urandom);
      push_sample($urandom_range(0, 11) == 0, gen_time, tgt, meas);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: update before any start, time clamps, error extremes
    push_sample(1'b0, 32'd0, 15'h3fff, 15'h4000);
    push_sample(1'b1, 32'd1000, 15'h0000, 15'h0000);
    push_sample(1'b0, 32'd1000, 15'd100, 15'd40);
    push_sample(1'b0, 32'd1007, 15'h7ff0, 15'd5);
    push_sample(1'b0, 32'd1500, 15'd300, 15'd20);
    push_sample(1'b0, 32'd900, 15'd20, 15'd300);
    push_sample(1'b0, 32'd905, 15'h4000, 15'h3fff);
    push_sample(1'b1, 32'hffffffff, 15'h7fff, 15'h7fff);
    push_sample(1'b0, 32'h0, 15'h2aaa, 15'h5555);
    drain();

    // largest gains and limit: integrator saturates both ways
    write_reg(REG_PROP_GAIN, 24'hffffff);
    write_reg(REG_INTEG_GAIN, 24'hffffff);
    write_reg(REG_TORQUE_LIMIT, 24'h01ffff);
    @(negedge clk_i);
    push_sample(1'b1, 32'd50, 15'h0000, 15'h0000);
    for (int i = 0; i < 4; i++) push_sample(1'b0, 32'd250 + 200 * i, 15'h3fff, 15'h4000);
    for (int i = 0; i < 3; i++) push_sample(1'b0, 32'd1200 + 200 * i, 15'h4000, 15'h3fff);
    drain();

    // zero limit, then rounding of tiny negative sums
    write_reg(REG_PROP_GAIN, 24'd1);
    write_reg(REG_INTEG_GAIN, 24'd0);
    write_reg(REG_TORQUE_LIMIT, 24'd0);
    @(negedge clk_i);
    push_sample(1'b0, 32'd1900, 15'h3fff, 15'h4000);
    push_sample(1'b0, 32'd1901, 15'h4000, 15'h3fff);
    drain();
    write_reg(REG_TORQUE_LIMIT, 24'd1);
    @(negedge clk_i);
    push_sample(1'b0, 32'd1902, 15'd0, 15'd1);
    push_sample(1'b0, 32'd1903, 15'd1, 15'd0);
    push_sample(1'b1, 32'd1904, 15'd0, 15'd1);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_reg(REG_PROP_GAIN, pick_value(GAIN_W));
      write_reg(REG_INTEG_GAIN, pick_value(GAIN_W));
      write_reg(REG_TORQUE_LIMIT, pick_value(LIMIT_W));
      @(negedge clk_i);
      if (p == 0) stall_req = 1'b1;
      if (p == 5) idle_on = 1'b0;
      random_burst(215);
      drain();
    end

    repeat (40) @(posedge clk_i);
    $display("speed loop run: %0d update and %0d start transactions over %0d register writes",
             n_updates, n_starts, n_cfg);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tspl_pkg.sv
rtl/tspl_ser_mul.sv
rtl/tspl_post.sv
rtl/timestamped_pi_speed_loop.sv
tb/timestamped_pi_speed_loop_tb.sv
